// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker in clvt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLVT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("table port check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLVT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("table port check failed");

`endif

// ===== rtl/core/clvt_pkg.sv =====
`timescale 1ns / 1ps
package clvt_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ID_W            = 11;
	localparam int PAYLOAD_W       = 64;
	localparam int SLOT_W          = 6;

	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic [SLOT_W-1:0]    slot_index;
		logic                 hit;
		logic                 dropped_full;
		logic                 entry_valid;
		logic [ID_W-1:0]      entry_id;
		logic [PAYLOAD_W-1:0] entry_payload;
	} res_t;

endpackage

// ===== rtl/core/clvt_ram.sv =====
`timescale 1ns / 1ps
module clvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/clvt_ctrl.sv =====
`timescale 1ns / 1ps
module clvt_ctrl #(
	parameter int TABLE_DEPTH = clvt_pkg::TABLE_DEPTH_DEF,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           kind,
	input  logic [clvt_pkg::ID_W-1:0]      can_id,
	input  logic [clvt_pkg::PAYLOAD_W-1:0] payload,
	input  logic [clvt_pkg::SLOT_W-1:0]    read_slot,
	output logic                           busy,
	output logic                           done,
	output clvt_pkg::res_t                 res,
	// identifier memory
	output logic                           id_we,
	output logic [IDX_W-1:0]               id_waddr,
	output logic [clvt_pkg::ID_W-1:0]      id_wdata,
	output logic                           id_re,
	output logic [IDX_W-1:0]               id_raddr,
	input  logic [clvt_pkg::ID_W-1:0]      id_rdata,
	// payload memory
	output logic                           pl_we,
	output logic [IDX_W-1:0]               pl_waddr,
	output logic [clvt_pkg::PAYLOAD_W-1:0] pl_wdata,
	output logic                           pl_re,
	output logic [IDX_W-1:0]               pl_raddr,
	input  logic [clvt_pkg::PAYLOAD_W-1:0] pl_rdata
);

	import clvt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD,
		ST_RD_OUT
	} state_t;

	state_t               state_q;
	logic [ID_W-1:0]      id_q;
	logic [PAYLOAD_W-1:0] data_q;
	logic [SLOT_W-1:0]    rslot_q;
	logic [CNT_W-1:0]     fill_q;
	logic [CNT_W-1:0]     addr_q;
	logic                 cmp_vld_q;
	logic [IDX_W-1:0]     cmp_idx_q;
	logic                 done_q;
	res_t                 res_q;

	logic             match;
	logic             more;
	logic             full;
	logic             rd_ok;
	logic [CMP_W-1:0] rs_ext;
	logic [CMP_W-1:0] fill_ext;
	logic [CMP_W-1:0] cmp_idx_ext;

	// The single identifier comparator checks the slot read in the previous cycle.
	assign match       = cmp_vld_q && (id_rdata == id_q);
	assign more        = (addr_q < fill_q);
	assign full        = (fill_q == CNT_W'(TABLE_DEPTH));
	assign rs_ext      = CMP_W'(rslot_q);
	assign fill_ext    = CMP_W'(fill_q);
	assign cmp_idx_ext = CMP_W'(cmp_idx_q);
	// Slots below the fill count are exactly the occupied ones.
	assign rd_ok       = (rs_ext < fill_ext);

	always_comb begin
		id_re    = 1'b0;
		id_raddr = addr_q[IDX_W-1:0];
		if (state_q == ST_SCAN && !match && more) begin
			id_re = 1'b1;
		end else if (state_q == ST_RD) begin
			id_re    = 1'b1;
			id_raddr = rs_ext[IDX_W-1:0];
		end
	end

	assign pl_re    = (state_q == ST_RD);
	assign pl_raddr = rs_ext[IDX_W-1:0];

	assign id_we    = (state_q == ST_SCAN) && !match && !more && !full;
	assign id_waddr = fill_q[IDX_W-1:0];
	assign id_wdata = id_q;

	assign pl_we    = (state_q == ST_SCAN) && (match || (!more && !full));
	assign pl_waddr = match ? cmp_idx_q : fill_q[IDX_W-1:0];
	assign pl_wdata = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			id_q      <= '0;
			data_q    <= '0;
			rslot_q   <= '0;
			fill_q    <= '0;
			addr_q    <= '0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						id_q      <= can_id;
						data_q    <= payload;
						rslot_q   <= read_slot;
						addr_q    <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= (kind == KIND_READ) ? ST_RD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						res_q   <= '{slot_index: cmp_idx_ext[SLOT_W-1:0], hit: 1'b1,
							dropped_full: 1'b0, entry_valid: 1'b0, entry_id: '0,
							entry_payload: '0};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (more) begin
						done_q    <= 1'b0;
						cmp_idx_q <= addr_q[IDX_W-1:0];
						cmp_vld_q <= 1'b1;
						addr_q    <= addr_q + CNT_W'(1);
					end else begin
						if (full) begin
							res_q <= '{slot_index: '0, hit: 1'b0, dropped_full: 1'b1,
								entry_valid: 1'b0, entry_id: '0, entry_payload: '0};
						end else begin
							res_q  <= '{slot_index: fill_ext[SLOT_W-1:0], hit: 1'b0,
								dropped_full: 1'b0, entry_valid: 1'b0, entry_id: '0,
								entry_payload: '0};
							fill_q <= fill_q + CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					done_q  <= 1'b0;
					state_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					res_q   <= '{slot_index: rslot_q, hit: 1'b0, dropped_full: 1'b0,
						entry_valid: rd_ok, entry_id: rd_ok ? id_rdata : '0,
						entry_payload: rd_ok ? pl_rdata : '0};
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/core/can_id_last_value_table.sv =====
`timescale 1ns / 1ps
// Last-value table for standard CAN identifiers. Pulse start while busy is low to hand in
// one item: kind 0 stores can_id/payload, kind 1 reads back slot read_slot. Exactly one
// result follows, shown for a single cycle with done high; the receiver cannot stall it
// and must take it in that cycle. A store walks the occupied slots one per cycle through
// the read port of the identifier memory and stops early on a match. A read passes through
// the ST_RD and ST_RD_OUT states before its result is shown.
// busy drops in the cycle that done is shown, so the next item may be started then.
// New identifiers fill slots in order from slot 0; when every slot is taken, a new
// identifier is dropped and dropped_full is reported. No clearing pass follows reset.
module can_id_last_value_table #(
	parameter int TABLE_DEPTH = clvt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           kind,
	input  logic [clvt_pkg::ID_W-1:0]      can_id,
	input  logic [clvt_pkg::PAYLOAD_W-1:0] payload,
	input  logic [clvt_pkg::SLOT_W-1:0]    read_slot,
	output logic                           done,
	output logic [clvt_pkg::SLOT_W-1:0]    slot_index,
	output logic                           hit,
	output logic                           dropped_full,
	output logic                           entry_valid,
	output logic [clvt_pkg::ID_W-1:0]      entry_id,
	output logic [clvt_pkg::PAYLOAD_W-1:0] entry_payload
);

	import clvt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	res_t                 res;
	logic                 id_we;
	logic [IDX_W-1:0]     id_waddr;
	logic [ID_W-1:0]      id_wdata;
	logic                 id_re;
	logic [IDX_W-1:0]     id_raddr;
	logic [ID_W-1:0]      id_rdata;
	logic                 pl_we;
	logic [IDX_W-1:0]     pl_waddr;
	logic [PAYLOAD_W-1:0] pl_wdata;
	logic                 pl_re;
	logic [IDX_W-1:0]     pl_raddr;
	logic [PAYLOAD_W-1:0] pl_rdata;

	clvt_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (kind),
		.can_id   (can_id),
		.payload  (payload),
		.read_slot(read_slot),
		.busy     (busy),
		.done     (done),
		.res      (res),
		.id_we    (id_we),
		.id_waddr (id_waddr),
		.id_wdata (id_wdata),
		.id_re    (id_re),
		.id_raddr (id_raddr),
		.id_rdata (id_rdata),
		.pl_we    (pl_we),
		.pl_waddr (pl_waddr),
		.pl_wdata (pl_wdata),
		.pl_re    (pl_re),
		.pl_raddr (pl_raddr),
		.pl_rdata (pl_rdata)
	);

	clvt_ram #(
		.WIDTH(ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_id_ram (
		.clk  (clk),
		.we   (id_we),
		.waddr(id_waddr),
		.wdata(id_wdata),
		.re   (id_re),
		.raddr(id_raddr),
		.rdata(id_rdata)
	);

	clvt_ram #(
		.WIDTH(PAYLOAD_W),
		.DEPTH(TABLE_DEPTH)
	) u_pl_ram (
		.clk  (clk),
		.we   (pl_we),
		.waddr(pl_waddr),
		.wdata(pl_wdata),
		.re   (pl_re),
		.raddr(pl_raddr),
		.rdata(pl_rdata)
	);

	assign slot_index    = res.slot_index;
	assign hit           = res.hit;
	assign dropped_full  = res.dropped_full;
	assign entry_valid   = res.entry_valid;
	assign entry_id      = res.entry_id;
	assign entry_payload = res.entry_payload;

endmodule

// ===== rtl/core/clvt_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clvt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [clvt_pkg::SLOT_W-1:0]    slot_index,
	input logic                           hit,
	input logic                           dropped_full,
	input logic                           entry_valid,
	input logic [clvt_pkg::ID_W-1:0]      entry_id,
	input logic [clvt_pkg::PAYLOAD_W-1:0] entry_payload
);

	// An accepted item keeps the block busy until its result is shown.
	`CLVT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// The block only goes idle by delivering a result.
	`CLVT_ASSERT_SAME(a_idle_with_result, $fell(busy), done)
	// Each item yields one result, so results never come in adjacent cycles.
	`CLVT_ASSERT_NEXT(a_single_strobe, done, !done)
	// A hit or drop result never carries both flags, and never carries read data.
	`CLVT_ASSERT_SAME(a_store_flags, done && (hit || dropped_full),
		!(hit && dropped_full) && !entry_valid && (entry_id == '0) && (entry_payload == '0))
	// A dropped frame names no slot.
	`CLVT_ASSERT_SAME(a_drop_slot, done && dropped_full, slot_index == '0)

endmodule

bind can_id_last_value_table clvt_checker u_clvt_checker (.*);
